### rtl/rgbla_pkg.sv
package rgbla_pkg;

    // Default table depth; the top level takes it as a parameter.
    localparam int MAX_ENTRIES_DEF = 32;

    // At most this many pixels come out of one frame.
    localparam int RESULT_CAP = 32;

    // Number of steps in one pulse period, and the index width into the pulse table.
    localparam int PULSE_STEPS = 256;
    localparam int PULSE_AW    = $clog2(PULSE_STEPS);

    // Width of the configuration address bus.
    localparam int APB_AW = 4;

    // Operand and product widths of the shared multiplier.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 29;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // floor(t / 125) for any 32-bit t is (t * T125_RECIP) >> T125_SHIFT.
    localparam logic [MUL_B_W-1:0] T125_RECIP = 29'h10624DD3;
    localparam int T125_SHIFT = 35;

    // floor(m * PULSE_STEPS / 2000) for m below 2000.
    localparam int PULSE_SHIFT = 23;
    localparam logic [63:0] PULSE_RECIP_W =
        ((64'(PULSE_STEPS) << PULSE_SHIFT) / 64'd2000) + 64'd1;
    localparam logic [MUL_B_W-1:0] PULSE_RECIP = PULSE_RECIP_W[MUL_B_W-1:0];

    // floor(y / 100) for y up to 25500 is (y * DIV100_RECIP) >> DIV100_SHIFT.
    localparam logic [MUL_B_W-1:0] DIV100_RECIP = 29'd5243;
    localparam int DIV100_SHIFT = 19;

    // Full gain in unsigned 1.15.
    localparam logic [15:0] GAIN_ONE = 16'h8000;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_SOLID = 3'd1,
        MODE_FAST  = 3'd2,
        MODE_SLOW  = 3'd3,
        MODE_PULSE = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        REG_LED_COUNT    = 2'd0,
        REG_STRIP_LENGTH = 2'd1,
        REG_FRAME_IVL    = 2'd2
    } t_reg;

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PHASE,
        ST_KIDX,
        ST_LUT,
        ST_RD,
        ST_GAIN,
        ST_GBSAVE,
        ST_CMUL,
        ST_DMUL,
        ST_DRES,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] bright;
        t_mode      mode;
    } t_entry;

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    // Pulse factor for table step k, unsigned 1.15. Evaluated only at elaboration
    // to fill the constant pulse table; sine comes from a Q30 Taylor series.
    function automatic logic [15:0] pulse_factor(input int unsigned k);
        logic [63:0] th;
        logic [63:0] x2;
        logic [63:0] tt;
        logic [63:0] s;
        logic [63:0] base;
        logic [63:0] delta;
        logic [63:0] f;
        logic        neg;
        th  = (64'd2 * PI_Q30 * 64'(k)) / 64'(PULSE_STEPS);
        neg = 1'b0;
        if (th >= PI_Q30) begin
            neg = 1'b1;
            th  = th - PI_Q30;
        end
        if (th > (PI_Q30 >> 1)) begin
            th = PI_Q30 - th;
        end
        x2 = (th * th) >> 30;
        tt = Q30_ONE - x2 / 64'd110;
        tt = Q30_ONE - ((x2 * tt) >> 30) / 64'd72;
        tt = Q30_ONE - ((x2 * tt) >> 30) / 64'd42;
        tt = Q30_ONE - ((x2 * tt) >> 30) / 64'd20;
        tt = Q30_ONE - ((x2 * tt) >> 30) / 64'd6;
        s  = (th * tt) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        base  = (64'd13 * Q30_ONE) / 64'd20;
        delta = (64'd7 * s) / 64'd20;
        f     = neg ? (base - delta) : (base + delta);
        f     = (f + 64'd16384) >> 15;
        if (f > 64'd32768) begin
            f = 64'd32768;
        end
        return f[15:0];
    endfunction

endpackage

### rtl/rgb_led_status_animator_unit.sv
// Channel   | Signals                                         | Direction
// ----------+-------------------------------------------------+----------
// input     | i_in_valid, o_in_stall, i_operation .. i_time_ms | into block
// output    | o_out_valid, i_out_stall, o_pixel_index .. last | out of block
// config    | psel, penable, pwrite, paddr, pwdata, prdata    | APB slave
//
// A set beat is accepted while idle and written into the LED table at that edge.
// A tick beat first tests the frame interval in CHECK; a due tick then runs PHASE, KIDX
// and LUT for phase and pulse lookup, then per pixel RD, GAIN, GBSAVE, a CMUL, DMUL, DRES
// pass per channel and EMIT, all through the one shared multiplier, stalling the input.
// A stalled output holds the next pixel's result in EMIT until the register frees.
// Reset is synchronous and active low: registers 8, 8, 25, last render 0, table dark.
module rgb_led_status_animator_unit #(
    parameter int MAX_ENTRIES = rgbla_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic signed [15:0]           i_target_index,
    input  logic signed [15:0]           i_red_in,
    input  logic signed [15:0]           i_green_in,
    input  logic signed [15:0]           i_blue_in,
    input  logic signed [15:0]           i_brightness_in,
    input  logic signed [7:0]            i_mode_in,
    input  logic [31:0]                  i_time_ms,
    // Output channel.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [4:0]                   o_pixel_index,
    output logic [7:0]                   o_red_out,
    output logic [7:0]                   o_green_out,
    output logic [7:0]                   o_blue_out,
    output logic                         o_frame_last,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rgbla_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    import rgbla_pkg::*;

    localparam int AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PIX_CAP = (MAX_ENTRIES < RESULT_CAP) ? MAX_ENTRIES : RESULT_CAP;

    // Control state.
    t_state            r_state, n_state;
    logic [5:0]        r_led_count;
    logic [5:0]        r_strip_len;
    logic [9:0]        r_interval;
    logic [31:0]       r_last, n_last;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic              r_ovalid, n_ovalid;
    logic [5:0]        r_pix, n_pix;
    logic [5:0]        r_n, n_n;
    logic [1:0]        r_ch, n_ch;

    // Working payload.
    logic [31:0]       r_time, n_time;
    logic              r_fast, n_fast;
    logic              r_slow, n_slow;
    logic [10:0]       r_mod, n_mod;
    logic [15:0]       r_pulse, n_pulse;
    logic              r_rdv, n_rdv;
    logic [7:0]        r_color [3];
    logic [7:0]        n_color [3];
    logic [22:0]       r_gb, n_gb;
    logic [7:0]        r_chan [3];
    logic [7:0]        n_chan [3];
    logic [4:0]        r_opix, n_opix;
    logic [7:0]        r_ored, n_ored;
    logic [7:0]        r_ogrn, n_ogrn;
    logic [7:0]        r_oblu, n_oblu;
    logic              r_olast, n_olast;

    // Shared multiplier and table memory.
    t_mul_req          w_mul;
    logic [PROD_W-1:0] w_prod;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    t_entry            w_wentry;
    logic              w_ram_re;
    logic [AW-1:0]     w_ram_raddr;
    logic [$bits(t_entry)-1:0] w_rdata;
    t_entry            w_entry;

    logic              w_in_acc;
    logic              w_cfg_wr;
    logic              w_idx_ok;
    logic              w_due;
    logic [5:0]        w_nmin;
    logic [25:0]       w_q125;
    logic [21:0]       w_q2000;
    logic [15:0]       w_gain;
    logic              w_out_free;
    logic              w_last_pix;
    logic [15:0]       w_lut [PULSE_STEPS];

    // The pulse curve is a constant table built at elaboration.
    for (genvar gk = 0; gk < PULSE_STEPS; gk++) begin : g_lut
        localparam logic [15:0] FACTOR = pulse_factor(int'(gk));
        assign w_lut[gk] = FACTOR;
    end

    rgbla_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul),
        .o_prod (w_prod)
    );

    rgbla_ram #(
        .WIDTH  ($bits(t_entry)),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_wentry),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Configuration access; the port never inserts wait states.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (t_reg'(paddr[3:2]))
            REG_LED_COUNT:    prdata = {26'd0, r_led_count};
            REG_STRIP_LENGTH: prdata = {26'd0, r_strip_len};
            REG_FRAME_IVL:    prdata = {22'd0, r_interval};
            default:          prdata = 32'd0;
        endcase
    end

    // A set beat lands in the table right away. The index must be non-negative and
    // below both the LED count and the table depth; levels are clamped and any
    // unknown mode is stored as solid.
    always_comb begin
        w_idx_ok = !i_target_index[15]
                   && (i_target_index[14:0] < {9'd0, r_led_count})
                   && (i_target_index[14:0] < 15'(MAX_ENTRIES));
        w_ram_we    = w_in_acc && (t_op'(i_operation) == OP_SET) && w_idx_ok;
        w_ram_waddr = i_target_index[AW-1:0];

        if (i_red_in[15])              w_wentry.red = 8'd0;
        else if (i_red_in > 16'sd255)  w_wentry.red = 8'd255;
        else                           w_wentry.red = i_red_in[7:0];

        if (i_green_in[15])             w_wentry.green = 8'd0;
        else if (i_green_in > 16'sd255) w_wentry.green = 8'd255;
        else                            w_wentry.green = i_green_in[7:0];

        if (i_blue_in[15])             w_wentry.blue = 8'd0;
        else if (i_blue_in > 16'sd255) w_wentry.blue = 8'd255;
        else                           w_wentry.blue = i_blue_in[7:0];

        if (i_brightness_in[15])             w_wentry.bright = 7'd0;
        else if (i_brightness_in > 16'sd100) w_wentry.bright = 7'd100;
        else                                 w_wentry.bright = i_brightness_in[6:0];

        if ($unsigned(i_mode_in) inside {[8'd0:8'd4]}) begin
            w_wentry.mode = t_mode'(i_mode_in[2:0]);
        end else begin
            w_wentry.mode = MODE_SOLID;
        end
    end

    // Entries never written since reset read as dark.
    assign w_entry = r_rdv ? t_entry'(w_rdata) : '0;

    // Frame gate: wrapping distance since the last render against the interval.
    assign w_due   = (r_time - r_last) >= {22'd0, r_interval};
    assign w_nmin  = (r_led_count < r_strip_len) ? r_led_count : r_strip_len;

    // Time split: q = t / 125 gives both blink phases; t mod 2000 follows from
    // q / 16 because 2000 = 2048 - 32 - 16 and only the low 11 bits matter.
    assign w_q125  = w_prod[T125_SHIFT +: 26];
    assign w_q2000 = w_q125[25:4];

    always_comb begin
        case (w_entry.mode)
            MODE_OFF:   w_gain = 16'd0;
            MODE_FAST:  w_gain = r_fast ? 16'd0 : GAIN_ONE;
            MODE_SLOW:  w_gain = r_slow ? 16'd0 : GAIN_ONE;
            MODE_PULSE: w_gain = r_pulse;
            default:    w_gain = GAIN_ONE;
        endcase
    end

    assign w_out_free = !r_ovalid || !i_out_stall;
    assign w_last_pix = ((r_pix + 6'd1) == r_n);

    always_comb begin
        n_state  = r_state;
        n_last   = r_last;
        n_ovalid = r_ovalid && i_out_stall;
        n_pix    = r_pix;
        n_n      = r_n;
        n_ch     = r_ch;
        n_time   = r_time;
        n_fast   = r_fast;
        n_slow   = r_slow;
        n_mod    = r_mod;
        n_pulse  = r_pulse;
        n_rdv    = r_rdv;
        n_color  = r_color;
        n_gb     = r_gb;
        n_chan   = r_chan;
        n_opix   = r_opix;
        n_ored   = r_ored;
        n_ogrn   = r_ogrn;
        n_oblu   = r_oblu;
        n_olast  = r_olast;
        w_mul    = '0;
        w_ram_re = 1'b0;
        w_ram_raddr = r_pix[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (t_op'(i_operation) == OP_TICK)) begin
                    n_time  = i_time_ms;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // Start the t / 125 product whether or not the frame is due.
                w_mul.en = 1'b1;
                w_mul.a  = r_time;
                w_mul.b  = T125_RECIP;
                n_pix    = 6'd0;
                n_n      = (w_nmin > 6'(PIX_CAP)) ? 6'(PIX_CAP) : w_nmin;
                if (!w_due) begin
                    n_state = ST_IDLE;
                end else begin
                    n_last = r_time;
                    if (w_nmin == 6'd0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_PHASE;
                    end
                end
            end
            ST_PHASE: begin
                n_fast  = w_q125[0];
                n_slow  = w_q125[2];
                n_mod   = r_time[10:0] + {w_q2000[5:0], 5'd0} + {w_q2000[6:0], 4'd0};
                n_state = ST_KIDX;
            end
            ST_KIDX: begin
                w_mul.en = 1'b1;
                w_mul.a  = {21'd0, r_mod};
                w_mul.b  = PULSE_RECIP;
                n_state  = ST_LUT;
            end
            ST_LUT: begin
                n_pulse = w_lut[w_prod[PULSE_SHIFT +: PULSE_AW]];
                n_state = ST_RD;
            end
            ST_RD: begin
                w_ram_re = 1'b1;
                n_rdv    = r_valid[r_pix[AW-1:0]];
                n_state  = ST_GAIN;
            end
            ST_GAIN: begin
                n_color[0] = w_entry.red;
                n_color[1] = w_entry.green;
                n_color[2] = w_entry.blue;
                w_mul.en   = 1'b1;
                w_mul.a    = {16'd0, w_gain};
                w_mul.b    = {22'd0, w_entry.bright};
                n_ch       = 2'd0;
                n_state    = ST_GBSAVE;
            end
            ST_GBSAVE: begin
                n_gb    = w_prod[22:0];
                n_state = ST_CMUL;
            end
            ST_CMUL: begin
                w_mul.en = 1'b1;
                w_mul.a  = {24'd0, r_color[r_ch]};
                w_mul.b  = {6'd0, r_gb};
                n_state  = ST_DMUL;
            end
            ST_DMUL: begin
                // Drop the 1.15 scale, then divide by 100 through a reciprocal.
                w_mul.en = 1'b1;
                w_mul.a  = {17'd0, w_prod[29:15]};
                w_mul.b  = DIV100_RECIP;
                n_state  = ST_DRES;
            end
            ST_DRES: begin
                n_chan[r_ch] = w_prod[DIV100_SHIFT +: 8];
                if (r_ch == 2'd2) begin
                    n_state = ST_EMIT;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = ST_CMUL;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_opix   = r_pix[4:0];
                    n_ored   = r_chan[0];
                    n_ogrn   = r_chan[1];
                    n_oblu   = r_chan[2];
                    n_olast  = w_last_pix;
                    if (w_last_pix) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pix   = r_pix + 6'd1;
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_led_count <= 6'd8;
            r_strip_len <= 6'd8;
            r_interval  <= 10'd25;
            r_last      <= 32'd0;
            r_valid     <= '0;
            r_ovalid    <= 1'b0;
            r_pix       <= 6'd0;
            r_n         <= 6'd0;
            r_ch        <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
            r_pix    <= n_pix;
            r_n      <= n_n;
            r_ch     <= n_ch;
            if (w_ram_we) begin
                r_valid[w_ram_waddr] <= 1'b1;
            end
            if (w_cfg_wr) begin
                case (t_reg'(paddr[3:2]))
                    REG_LED_COUNT:    r_led_count <= pwdata[5:0];
                    REG_STRIP_LENGTH: r_strip_len <= pwdata[5:0];
                    REG_FRAME_IVL:    r_interval  <= pwdata[9:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_time  <= n_time;
        r_fast  <= n_fast;
        r_slow  <= n_slow;
        r_mod   <= n_mod;
        r_pulse <= n_pulse;
        r_rdv   <= n_rdv;
        r_color <= n_color;
        r_gb    <= n_gb;
        r_chan  <= n_chan;
        r_opix  <= n_opix;
        r_ored  <= n_ored;
        r_ogrn  <= n_ogrn;
        r_oblu  <= n_oblu;
        r_olast <= n_olast;
    end

    assign o_out_valid   = r_ovalid;
    assign o_pixel_index = r_opix;
    assign o_red_out     = r_ored;
    assign o_green_out   = r_ogrn;
    assign o_blue_out    = r_oblu;
    assign o_frame_last  = r_olast;

    // A set beat never starts the sequencer.
    a_set_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (t_op'(i_operation) == OP_SET)) |=> (r_state == ST_IDLE))
        else $error("set beat left the idle state");

    // A due tick records its own time as the last render time.
    a_last_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CHECK) && w_due) |=> (r_last == $past(r_time)))
        else $error("last render time not updated by a due tick");

    // Channel counter only walks red, green and blue.
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ch != 2'd3))
        else $error("channel counter out of range");

    // A pixel leaving EMIT always shows up on the output register.
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && w_out_free) |=> o_out_valid)
        else $error("emitted pixel not presented");

endmodule

### rtl/rgbla_ram.sv
module rgbla_ram #(
    parameter int WIDTH  = 34,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rgbla_mul.sv
module rgbla_mul (
    input  logic                             i_clk,
    input  rgbla_pkg::t_mul_req              i_req,
    output logic [rgbla_pkg::PROD_W-1:0]     o_prod
);

    import rgbla_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] w_prod;

    // Unsigned 32 x 29 product, registered before anyone uses it.
    assign w_prod = {{MUL_B_W{1'b0}}, i_req.a} * {{MUL_A_W{1'b0}}, i_req.b};

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= w_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

### tb/rgb_led_status_animator_unit_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the RGB status LED animator. Set and tick beats go in on
// the input channel, rendered pixels come back on the output channel, and a small
// frame checker predicts every pixel from its own copy of the LED table, the
// last render time and the three configuration registers.
module rgb_led_status_animator_unit_test;
    import rgbla_pkg::*;

    localparam int TABLE_DEPTH     = 32;
    localparam int FRAME_CAP       = 32;
    localparam int BREATHE_STEPS   = 256;
    // A due tick with an empty frame still passes through the check state in the
    // block, so registers are only touched after this many quiet cycles.
    localparam int SETTLE_CYCLES   = 64;
    // Long enough to outlast a full 32 pixel frame, so the block must back up.
    localparam int HOLD_OFF_CYCLES = 700;
    // Slowest legal run is roughly 300 beats times a 32 pixel frame with every pixel
    // held by the longest receiver stall burst; this leaves several times that.
    localparam int CYCLE_LIMIT     = 2000000;

    // One beat on the input channel. Fields that the operation does not use are
    // still filled with random values so that every input bit toggles.
    typedef struct {
        t_op                op;
        logic signed [15:0] target;
        logic signed [15:0] red;
        logic signed [15:0] green;
        logic signed [15:0] blue;
        logic signed [15:0] bright;
        logic signed [7:0]  mode;
        logic [31:0]        stamp_ms;
    } t_beat;

    // One beat on the output channel.
    typedef struct {
        logic [4:0] pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_pixel;

    // Clamp a signed request into 0..top.
    function automatic logic [7:0] clip_level(input logic signed [15:0] v, input int top);
        if (v < 0) begin
            return 8'd0;
        end
        if (v > top) begin
            return 8'(top);
        end
        return v[7:0];
    endfunction

    // Breathing gain for one step of the 2000 ms pulse, unsigned 1.15. The sine
    // is a Q30 odd Taylor series to x^11 in Horner form, truncating each divide,
    // on an angle folded into the first quadrant with its sign kept aside.
    function automatic longint unsigned breathe_gain(input int unsigned k_step);
        longint unsigned pi_q30  = 64'd3373259426;
        longint unsigned one_q30 = 64'd1 << 30;
        longint unsigned ang;
        longint unsigned sq;
        longint unsigned poly;
        longint unsigned sine;
        longint unsigned level;
        int unsigned     divs[5] = '{110, 72, 42, 20, 6};
        bit              lower_half;
        ang = (64'd2 * pi_q30 * 64'(k_step % BREATHE_STEPS)) / BREATHE_STEPS;
        lower_half = (ang >= pi_q30);
        if (lower_half) begin
            ang = ang - pi_q30;
        end
        if (ang > pi_q30 / 2) begin
            ang = pi_q30 - ang;
        end
        sq   = (ang * ang) >> 30;
        poly = one_q30;
        foreach (divs[j]) begin
            poly = one_q30 - ((sq * poly) >> 30) / divs[j];
        end
        sine = (ang * poly) >> 30;
        if (sine > one_q30) begin
            sine = one_q30;
        end
        // 0.3 + 0.7 * (0.5 + 0.5 sin) is 0.65 plus or minus 0.35 |sin|.
        level = (64'd13 * one_q30) / 20;
        if (lower_half) begin
            level = level - (64'd7 * sine) / 20;
        end else begin
            level = level + (64'd7 * sine) / 20;
        end
        level = (level + 64'd16384) >> 15;
        if (level > 64'd32768) begin
            level = 64'd32768;
        end
        return level;
    endfunction

    // Gain of one LED at time t, before brightness, unsigned 1.15.
    function automatic longint unsigned lamp_gain(input t_mode m, input logic [31:0] t);
        case (m)
            MODE_OFF:   return 0;
            MODE_FAST:  return ((t / 125) % 2 == 0) ? 32768 : 0;
            MODE_SLOW:  return ((t / 500) % 2 == 0) ? 32768 : 0;
            MODE_PULSE: return breathe_gain(((t % 2000) * BREATHE_STEPS) / 2000);
            default:    return 32768;
        endcase
    endfunction

    // Frame checker: mirrors the block's state and holds the pixels still owed.
    class led_frame_checker;
        t_entry      lamps[TABLE_DEPTH];
        logic [31:0] last_frame_ms;
        logic [5:0]  lamps_used;
        logic [5:0]  strip_pixels;
        logic [9:0]  frame_gap_ms;
        t_pixel      pending_pixels[$];
        int          mismatches;
        int          beats_taken;
        int          frames_rendered;
        int          pixels_matched;

        function new();
            foreach (lamps[i]) begin
                lamps[i] = '0;
            end
            last_frame_ms   = '0;
            lamps_used      = 6'd8;
            strip_pixels    = 6'd8;
            frame_gap_ms    = 10'd25;
            mismatches      = 0;
            beats_taken     = 0;
            frames_rendered = 0;
            pixels_matched  = 0;
        endfunction

        function void set_register(input t_reg r, input logic [31:0] value);
            case (r)
                REG_LED_COUNT:    lamps_used   = value[5:0];
                REG_STRIP_LENGTH: strip_pixels = value[5:0];
                REG_FRAME_IVL:    frame_gap_ms = value[9:0];
                default: ;
            endcase
        endfunction

        // Note one accepted input beat and queue the pixels it renders.
        function void take_beat(input t_beat b);
            int              slot;
            int              code;
            int              n;
            logic [31:0]     elapsed;
            longint unsigned gain;
            t_pixel          px;
            beats_taken++;
            if (b.op == OP_SET) begin
                slot = b.target;
                code = b.mode;
                if (slot < 0 || slot >= int'(lamps_used) || slot >= TABLE_DEPTH) begin
                    return;
                end
                lamps[slot].red    = clip_level(b.red, 255);
                lamps[slot].green  = clip_level(b.green, 255);
                lamps[slot].blue   = clip_level(b.blue, 255);
                lamps[slot].bright = 7'(clip_level(b.bright, 100));
                lamps[slot].mode   = (code >= 0 && code <= 4) ? t_mode'(code) : MODE_SOLID;
                return;
            end
            // Wrapping difference, so a tick after the counter rolls over still renders.
            elapsed = b.stamp_ms - last_frame_ms;
            if (elapsed < 32'(frame_gap_ms)) begin
                return;
            end
            last_frame_ms = b.stamp_ms;
            n = (lamps_used < strip_pixels) ? lamps_used : strip_pixels;
            if (n > TABLE_DEPTH) begin
                n = TABLE_DEPTH;
            end
            if (n > FRAME_CAP) begin
                n = FRAME_CAP;
            end
            if (n > 0) begin
                frames_rendered++;
            end
            for (int i = 0; i < n; i++) begin
                gain = lamp_gain(lamps[i].mode, b.stamp_ms) * lamps[i].bright;
                px.pixel     = 5'(i);
                px.red       = 8'((lamps[i].red * gain) / 3276800);
                px.green     = 8'((lamps[i].green * gain) / 3276800);
                px.blue      = 8'((lamps[i].blue * gain) / 3276800);
                px.frame_end = (i == n - 1);
                pending_pixels.push_back(px);
            end
        endfunction

        function void compare_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Check one accepted output beat against the oldest pending pixel.
        function void match_pixel(input t_pixel got);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                $error("Pixel beat for index %0d arrived with no frame pending.", got.pixel);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            pixels_matched++;
            compare_field("pixel_index", 8'(want.pixel), 8'(got.pixel));
            compare_field("red_out", want.red, got.red);
            compare_field("green_out", want.green, got.green);
            compare_field("blue_out", want.blue, got.blue);
            compare_field("frame_last", 8'(want.frame_end), 8'(got.frame_end));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_beat                 offered;
    logic                  out_valid;
    logic                  out_stall;
    logic [4:0]            out_pixel;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic                  out_frame_end;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    led_frame_checker      board;
    // Chance of an idle burst is one in idle_odds per beat or cycle; 0 means none.
    int                    idle_odds = 0;
    // Set by the stimulus, cleared by the receiver once it starts its long hold-off.
    bit                    hold_off_request = 1'b0;
    logic [31:0]           now_ms = '0;
    int                    phases_run = 0;

    always #10 clk = ~clk;

    rgb_led_status_animator_unit #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (offered.op),
        .i_target_index (offered.target),
        .i_red_in       (offered.red),
        .i_green_in     (offered.green),
        .i_blue_in      (offered.blue),
        .i_brightness_in(offered.bright),
        .i_mode_in      (offered.mode),
        .i_time_ms      (offered.stamp_ms),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_pixel_index  (out_pixel),
        .o_red_out      (out_red),
        .o_green_out    (out_green),
        .o_blue_out     (out_blue),
        .o_frame_last   (out_frame_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Every field random; the base of all other beats, and the noise beats themselves.
    function automatic t_beat noise_beat();
        t_beat b;
        b.op       = t_op'($urandom_range(0, 1));
        b.target   = 16'($urandom);
        b.red      = 16'($urandom);
        b.green    = 16'($urandom);
        b.blue     = 16'($urandom);
        b.bright   = 16'($urandom);
        b.mode     = 8'($urandom);
        b.stamp_ms = $urandom;
        return b;
    endfunction

    function automatic t_beat set_beat(input int slot, input int r, input int g, input int bl,
                                       input int br, input int m);
        t_beat b;
        b        = noise_beat();
        b.op     = OP_SET;
        b.target = 16'(slot);
        b.red    = 16'(r);
        b.green  = 16'(g);
        b.blue   = 16'(bl);
        b.bright = 16'(br);
        b.mode   = 8'(m);
        return b;
    endfunction

    function automatic t_beat tick_beat(input logic [31:0] t);
        t_beat b;
        b          = noise_beat();
        b.op       = OP_TICK;
        b.stamp_ms = t;
        return b;
    endfunction

    // Mostly a legal level, now and then any 16-bit value to exercise the clamp.
    function automatic int pick_level(input int top);
        if ($urandom_range(0, 4) == 0) begin
            return int'($signed(16'($urandom)));
        end
        return $urandom_range(0, top);
    endfunction

    // Random traffic: well-formed sets to LEDs in use, ticks that mostly arrive once
    // the frame interval has passed, and a share of fully random noise beats.
    function automatic t_beat random_beat();
        t_beat b;
        int    pick;
        int    used;
        int    gap;
        int    m;
        pick = $urandom_range(0, 99);
        used = board.lamps_used;
        gap  = board.frame_gap_ms;
        if (pick < 45) begin
            m = ($urandom_range(0, 6) == 0) ? int'($signed(8'($urandom)))
                                            : $urandom_range(0, 4);
            b = set_beat((used == 0) ? $urandom_range(0, 3) : $urandom_range(0, used - 1),
                         pick_level(255), pick_level(255), pick_level(255),
                         pick_level(100), m);
        end else if (pick < 85) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                now_ms = now_ms + $urandom_range(gap, gap + 300);
            end else if (pick < 9) begin
                now_ms = now_ms + $urandom_range(0, gap);
            end else begin
                now_ms = $urandom;
            end
            b = tick_beat(now_ms);
        end else begin
            b = noise_beat();
            if (b.op == OP_TICK) begin
                now_ms = b.stamp_ms;
            end
        end
        return b;
    endfunction

    // Offer one beat and return at the edge that accepts it. Valid stays high, so
    // back-to-back beats need no dead cycle; an idle burst drops it first.
    task automatic send_beat(input t_beat b);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        offered  <= b;
        do begin
            @(posedge clk);
        end while (in_stall);
    endtask

    // Stop offering, wait for every predicted pixel, then let any beat that renders
    // nothing finish inside the block before the registers are touched.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_pixels.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup phase, access phase, then psel drops and the bus idles before anything else.
    task automatic reg_write(input t_reg r, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(posedge clk);
        end while (!pready);
        board.set_register(r, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [5:0] count, input logic [5:0] pixels,
                             input logic [9:0] gap);
        reg_write(REG_LED_COUNT, 32'(count));
        reg_write(REG_STRIP_LENGTH, 32'(pixels));
        reg_write(REG_FRAME_IVL, 32'(gap));
        phases_run++;
    endtask

    task automatic run_phase(input int beats, input int odds);
        idle_odds = odds;
        repeat (beats) send_beat(random_beat());
        drain();
    endtask

    // Both channels are sampled at the rising edge, before any of this step's
    // nonblocking updates land, so the handshake seen here is the one the block saw.
    always @(posedge clk) begin
        t_pixel seen;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                board.take_beat(offered);
            end
            if (out_valid && !out_stall) begin
                seen.pixel     = out_pixel;
                seen.red       = out_red;
                seen.green     = out_green;
                seen.blue      = out_blue;
                seen.frame_end = out_frame_end;
                board.match_pixel(seen);
            end
        end
    end

    // Receiver: random stall bursts while idling is on, plus one long hold-off on
    // request that lets the block fill up and push back on its input.
    initial begin
        int burst;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                burst = $urandom_range(1, 14);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a hung handshake or a lost pixel ends up here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Run stopped after %0d cycles with %0d pixels still pending.",
                 CYCLE_LIMIT, board.pending_pixels.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        board    = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        offered  <= noise_beat();
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at the reset settings: 8 LEDs, 8 pixels, 25 ms interval.
        idle_odds = 4;
        // The last render time starts at zero, so 0 and 24 ms are too early and
        // 25 ms renders a frame of dark pixels from the cleared table.
        send_beat(tick_beat(32'd0));
        send_beat(tick_beat(32'd24));
        send_beat(tick_beat(32'd25));
        // One LED per mode, with requests at both ends of the clamps.
        send_beat(set_beat(0, 32767, -32768, 255, 32767, MODE_SOLID));
        send_beat(set_beat(1, -1, 256, 128, 100, MODE_FAST));
        send_beat(set_beat(2, 255, 255, 255, 50, MODE_SLOW));
        send_beat(set_beat(3, 200, 100, 50, 100, MODE_PULSE));
        send_beat(set_beat(4, 255, 255, 255, 100, MODE_OFF));
        // Unknown modes fall back to solid.
        send_beat(set_beat(5, 10, 20, 30, -32768, -128));
        send_beat(set_beat(6, 255, 0, 255, 101, 127));
        send_beat(set_beat(7, 1, 2, 3, 99, 5));
        // Writes outside the LEDs in use are dropped.
        send_beat(set_beat(-1, 255, 255, 255, 100, MODE_SOLID));
        send_beat(set_beat(8, 255, 255, 255, 100, MODE_SOLID));
        send_beat(set_beat(32767, 255, 255, 255, 100, MODE_SOLID));
        send_beat(set_beat(-32768, 255, 255, 255, 100, MODE_SOLID));
        // Both blinks on, then fast off, then slow off; pulse at several steps.
        send_beat(tick_beat(32'd1000));
        send_beat(tick_beat(32'd1125));
        send_beat(tick_beat(32'd1500));
        send_beat(tick_beat(32'd1510));
        send_beat(tick_beat(32'd1750));
        // Across the wrap of the millisecond counter: 6 ms is too early, 25 ms is due.
        send_beat(tick_beat(32'hFFFF_FFFF));
        send_beat(tick_beat(32'd5));
        send_beat(tick_beat(32'd24));
        now_ms = 32'd24;
        drain();
        phases_run++;
        run_phase(40, 4);

        // Full table, zero interval so every tick renders, and one long output
        // hold-off while the sender keeps offering beats.
        configure(6'd32, 6'd32, 10'd0);
        hold_off_request = 1'b1;
        run_phase(50, 3);

        // Counts beyond the table and the largest interval, with no idling.
        configure(6'd63, 6'd63, 10'd1023);
        run_phase(40, 0);

        // No LEDs in use: due ticks move the render time but emit nothing.
        configure(6'd0, 6'd8, 10'd1);
        run_phase(30, 5);

        // Frame length set by the LED count, then by the strip length.
        configure(6'd5, 6'd20, 10'd100);
        run_phase(40, 2);
        configure(6'd20, 6'd3, 10'd7);
        run_phase(40, 4);

        // Last stretch: random settings and steady traffic with no idling on either side.
        configure(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  10'($urandom_range(0, 1023)));
        run_phase(40, 0);

        $display("Covered %0d accepted beats over %0d register settings, from reset onward.",
                 board.beats_taken, phases_run);
        $display("%0d frames rendered, %0d pixels compared, %0d mismatches.",
                 board.frames_rendered, board.pixels_matched, board.mismatches);
        if (board.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/rgbla_pkg.sv
rtl/rgbla_ram.sv
rtl/rgbla_mul.sv
rtl/rgb_led_status_animator_unit.sv
tb/rgb_led_status_animator_unit_test.sv
